FILE: hdl/phdm_pkg.sv
// Package for the polar joystick to H-bridge duty mixer.
// Holds the shared types, angle and level constants, the duty scaling table
// and the sine series used to build the quarter-wave sine table.
`default_nettype none

package phdm_pkg;

    // Default sine table precision (fraction bits of the Q1.F entries)
    localparam int unsigned SINE_FRACTION_BITS_DEF = 16;

    // Angle landmarks in whole degrees
    localparam logic [9:0] QUARTER_DEG       = 10'd90;
    localparam logic [9:0] HALF_DEG          = 10'd180;
    localparam logic [9:0] THREE_QUARTER_DEG = 10'd270;
    localparam logic [9:0] FULL_DEG          = 10'd360;

    // Spin-in-place windows
    localparam logic [8:0] SPIN_FWD_LO = 9'd15;
    localparam logic [8:0] SPIN_FWD_HI = 9'd345;
    localparam logic [8:0] SPIN_BWD_LO = 9'd165;
    localparam logic [8:0] SPIN_BWD_HI = 9'd195;

    // Level clamp and full-scale duty
    localparam int unsigned LEVEL_MAX = 100;
    localparam int unsigned DUTY_FULL = 255;

    // pi/180 in Q60 source constant and Taylor divisors (2k)(2k+1)
    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
    localparam logic [63:0] DEG_TO_RAD_Q60 = PI_Q60 / 64'd180;
    localparam logic [63:0] TAYLOR_DIV [1:10] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
        64'd156, 64'd210, 64'd272, 64'd342, 64'd420
    };

    // One product term: magnitude and direction
    typedef struct packed {
        logic [6:0] mag;
        logic       neg;
    } t_polar;

    // The four bridge duties, held between beats
    typedef struct packed {
        logic [7:0] left_a;
        logic [7:0] left_b;
        logic [7:0] right_a;
        logic [7:0] right_b;
    } t_duties;

    // Level to duty table: level * 255 / 100, truncated
    typedef logic [7:0] t_scale_lut [0:LEVEL_MAX];

    function automatic t_scale_lut build_scale_lut();
        t_scale_lut lut;
        for (int unsigned i = 0; i <= LEVEL_MAX; i++) begin
            lut[i] = 8'((i * DUTY_FULL) / LEVEL_MAX);
        end
        return lut;
    endfunction

    localparam t_scale_lut SCALE_LUT = build_scale_lut();

    // sin(d degrees) in Q30 by an eleven-term Taylor series; elaboration only
    function automatic logic [63:0] sine_q30(input int unsigned d);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        x    = (64'(d) * DEG_TO_RAD_Q60) >> 30;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (int unsigned k = 1; k <= 10; k++) begin
            term = (term * x2) >> 30;
            term = term / TAYLOR_DIV[k];
            if (k[0]) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return sum;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/phdm_polar_part.sv
// One polar product: trunc(speed * sin(angle)) as magnitude and sign.
// Folds the angle onto a quarter-wave sine table built at elaboration.
// Depends on phdm_pkg.
`default_nettype none

module phdm_polar_part #(
    parameter int unsigned SINE_FRACTION_BITS = phdm_pkg::SINE_FRACTION_BITS_DEF
) (
    input  logic [6:0]       i_speed,
    input  logic [9:0]       i_angle,
    output phdm_pkg::t_polar o_part
);
    import phdm_pkg::*;

    localparam int unsigned SW     = SINE_FRACTION_BITS + 1;
    localparam int unsigned PW     = SW + 7;
    localparam int unsigned RND_SH = 30 - SINE_FRACTION_BITS;
    localparam int unsigned QDEG   = 90;

    typedef logic [SW-1:0] t_sine_rom [0:QDEG];

    // Round each Q30 entry to nearest, ties up, at the table precision
    function automatic t_sine_rom build_rom();
        t_sine_rom rom;
        for (int unsigned d = 0; d <= QDEG; d++) begin
            rom[d] = SW'((sine_q30(d) + (64'd1 << (RND_SH - 1))) >> RND_SH);
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_rom();

    logic [9:0]    angle_mod;
    logic [6:0]    fold_deg;
    logic          fold_neg;
    logic [SW-1:0] sine;
    logic [PW-1:0] prod;
    logic [6:0]    mag;

    // Wrap to one turn; the input never reaches two turns
    assign angle_mod = (i_angle >= FULL_DEG) ? (i_angle - FULL_DEG) : i_angle;

    // Fold onto the first quadrant and note the sign
    always_comb begin
        if (angle_mod <= QUARTER_DEG) begin
            fold_deg = 7'(angle_mod);
            fold_neg = 1'b0;
        end else if (angle_mod <= HALF_DEG) begin
            fold_deg = 7'(HALF_DEG - angle_mod);
            fold_neg = 1'b0;
        end else if (angle_mod <= THREE_QUARTER_DEG) begin
            fold_deg = 7'(angle_mod - HALF_DEG);
            fold_neg = 1'b1;
        end else begin
            fold_deg = 7'(FULL_DEG - angle_mod);
            fold_neg = 1'b1;
        end
    end

    // Look up, multiply and drop the fraction
    assign sine = SINE_ROM[fold_deg];
    assign prod = PW'(i_speed) * PW'(sine);
    assign mag  = 7'(prod >> SINE_FRACTION_BITS);

    // A zero product carries no sign
    assign o_part.mag = mag;
    assign o_part.neg = fold_neg && (mag != 7'd0);

endmodule

`default_nettype wire

FILE: hdl/phdm_duty_select.sv
// Duty selection: spin windows, quadrant steering, clamp and scale.
// Holds the previous duties when forward or turn is zero off the windows.
// Depends on phdm_pkg.
`default_nettype none

module phdm_duty_select (
    input  logic              i_moving,
    input  logic [8:0]        i_angle_deg,
    input  phdm_pkg::t_polar  i_fwd,
    input  phdm_pkg::t_polar  i_turn,
    input  phdm_pkg::t_duties i_held,
    output phdm_pkg::t_duties o_duties
);
    import phdm_pkg::*;

    localparam logic [7:0] LEVEL_MAX_W = 8'(LEVEL_MAX);

    logic [7:0] sum;
    logic [6:0] lvl_both;
    logic [6:0] lvl_fwd;
    logic [7:0] both;
    logic [7:0] fonly;
    logic       fpos;
    logic       tpos;
    logic       spin_fwd;
    logic       spin_bwd;

    // Clamp both levels to full scale and convert to duty
    assign sum      = {1'b0, i_fwd.mag} + {1'b0, i_turn.mag};
    assign lvl_both = (sum > LEVEL_MAX_W) ? 7'(LEVEL_MAX) : sum[6:0];
    assign lvl_fwd  = ({1'b0, i_fwd.mag} > LEVEL_MAX_W) ? 7'(LEVEL_MAX) : i_fwd.mag;
    assign both     = SCALE_LUT[lvl_both];
    assign fonly    = SCALE_LUT[lvl_fwd];

    assign fpos = (i_fwd.mag != 7'd0) && !i_fwd.neg;
    assign tpos = (i_turn.mag != 7'd0) && !i_turn.neg;

    assign spin_fwd = (i_angle_deg <= SPIN_FWD_LO) || (i_angle_deg >= SPIN_FWD_HI);
    assign spin_bwd = (i_angle_deg >= SPIN_BWD_LO) && (i_angle_deg <= SPIN_BWD_HI);

    // Pick direction pins and which side gets the combined level
    always_comb begin
        o_duties = i_held;
        if (!i_moving) begin
            o_duties = '0;
        end else if (spin_fwd) begin
            o_duties = '{left_a: 8'd0, left_b: both, right_a: both, right_b: 8'd0};
        end else if (spin_bwd) begin
            o_duties = '{left_a: both, left_b: 8'd0, right_a: 8'd0, right_b: both};
        end else if (i_fwd.neg && tpos) begin
            o_duties = '{left_a: both, left_b: 8'd0, right_a: fonly, right_b: 8'd0};
        end else if (i_fwd.neg && i_turn.neg) begin
            o_duties = '{left_a: fonly, left_b: 8'd0, right_a: both, right_b: 8'd0};
        end else if (fpos && tpos) begin
            o_duties = '{left_a: 8'd0, left_b: both, right_a: 8'd0, right_b: fonly};
        end else if (fpos && i_turn.neg) begin
            o_duties = '{left_a: 8'd0, left_b: fonly, right_a: 8'd0, right_b: both};
        end
    end

endmodule

`default_nettype wire

FILE: hdl/polar_to_hbridge_drive_mix_unit.sv
// Top level of the polar joystick to H-bridge duty mixer.
// Input register, sine/cosine products, duty selection and result register.
// Depends on phdm_pkg, phdm_polar_part and phdm_duty_select.
//
//  channel | signals                                      | direction
//  --------+----------------------------------------------+----------
//  in      | i_in_valid, o_in_ready, i_speed, i_angle_deg | sink
//  out     | o_out_valid, i_out_ready, o_left_duty_a/b,   | source
//          | o_right_duty_a/b, o_moving                   |
//
// Each beat passes the input register, then the result register; one beat per
// cycle unless the result stalls; lookup, multiply and selection are in between.
// Synchronous active-low reset empties both stages and clears the held duties.
// A stalled result holds in its register; the input stage keeps accepting
// while the result register is free or being emptied in the same cycle.
`default_nettype none

module polar_to_hbridge_drive_mix_unit #(
    parameter int unsigned SINE_FRACTION_BITS = phdm_pkg::SINE_FRACTION_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [6:0] i_speed,
    input  logic [8:0] i_angle_deg,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_left_duty_a,
    output logic [7:0] o_left_duty_b,
    output logic [7:0] o_right_duty_a,
    output logic [7:0] o_right_duty_b,
    output logic       o_moving
);
    import phdm_pkg::*;

    logic       r_in_valid;
    logic [6:0] r_speed;
    logic [8:0] r_angle;
    logic       r_out_valid;
    t_duties    r_duties;
    logic       r_moving;

    t_duties    n_duties;
    logic       n_moving;
    t_polar     fwd;
    t_polar     turn;
    logic       out_adv;
    logic       in_ready;

    // Advance the result stage when it is empty or being taken
    assign out_adv  = !r_out_valid || i_out_ready;
    assign in_ready = !r_in_valid || out_adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in_valid) begin
            r_speed <= i_speed;
            r_angle <= i_angle_deg;
        end
    end

    // Forward from sine, turn from cosine (angle plus a quarter turn)
    phdm_polar_part #(
        .SINE_FRACTION_BITS(SINE_FRACTION_BITS)
    ) u_fwd (
        .i_speed (r_speed),
        .i_angle ({1'b0, r_angle}),
        .o_part  (fwd)
    );

    phdm_polar_part #(
        .SINE_FRACTION_BITS(SINE_FRACTION_BITS)
    ) u_turn (
        .i_speed (r_speed),
        .i_angle ({1'b0, r_angle} + QUARTER_DEG),
        .o_part  (turn)
    );

    assign n_moving = (r_speed != 7'd0);

    phdm_duty_select u_select (
        .i_moving    (n_moving),
        .i_angle_deg (r_angle),
        .i_fwd       (fwd),
        .i_turn      (turn),
        .i_held      (r_duties),
        .o_duties    (n_duties)
    );

    // Result register; its duties are also the held state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_duties    <= '0;
            r_moving    <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_duties <= n_duties;
                r_moving <= n_moving;
            end
        end
    end

    assign o_in_ready     = in_ready;
    assign o_out_valid    = r_out_valid;
    assign o_left_duty_a  = r_duties.left_a;
    assign o_left_duty_b  = r_duties.left_b;
    assign o_right_duty_a = r_duties.right_a;
    assign o_right_duty_b = r_duties.right_b;
    assign o_moving       = r_moving;

endmodule

`default_nettype wire

FILE: hdl/phdm_checker.sv
// Port-level checks for the duty mixer top level, with its bind statement.
// Watches only the top-level ports; no package dependency.
`default_nettype none

module phdm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_left_duty_a,
    input logic [7:0] o_left_duty_b,
    input logic [7:0] o_right_duty_a,
    input logic [7:0] o_right_duty_b,
    input logic       o_moving
);

    // Reset empties the result stage
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result beat present after reset");

    // A stalled result beat stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_left_duty_a) && $stable(o_left_duty_b) &&
            $stable(o_right_duty_a) && $stable(o_right_duty_b) && $stable(o_moving))
        else $error("result payload changed while stalled");

    // Stopping clears every duty
    a_stop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_moving |->
            o_left_duty_a == 8'd0 && o_left_duty_b == 8'd0 &&
            o_right_duty_a == 8'd0 && o_right_duty_b == 8'd0)
        else $error("duties nonzero while stopped");

    // Never drive both inputs of one bridge
    a_no_shoot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_left_duty_a == 8'd0 || o_left_duty_b == 8'd0) &&
            (o_right_duty_a == 8'd0 || o_right_duty_b == 8'd0))
        else $error("both inputs of one bridge driven");

endmodule

bind polar_to_hbridge_drive_mix_unit phdm_checker u_phdm_checker (.*);

`default_nettype wire
